// ===== design/hhc_pkg.sv =====
`default_nettype none

package hhc_pkg;

	localparam int SLOTS      = 16;
	localparam int COUNT_BITS = 32;
	localparam int USED_W     = $clog2(SLOTS + 1);
	localparam int KEY_W      = 64;
	localparam int TOTAL_W    = 48;
	localparam int CFG_W      = 5;
	localparam int OUT_CNT_W  = 32;
	localparam int OUT_USED_W = 5;

	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

	localparam logic OP_UPDATE = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	localparam logic STATUS_OK       = 1'b0;
	localparam logic STATUS_OVERFLOW = 1'b1;

	typedef enum logic [1:0] {
		ACT_NONE = 2'd0,
		ACT_INC  = 2'd1,
		ACT_FILL = 2'd2,
		ACT_DEC  = 2'd3
	} action_t;

	typedef struct packed {
		logic                  vld;
		logic                  hit;
		logic [COUNT_BITS-1:0] hit_cnt;
		logic                  free_seen;
		logic [USED_W-1:0]     used;
		logic [USED_W-1:0]     ones;
	} link_t;

endpackage

`default_nettype wire

// ===== design/hhc_cell.sv =====
`default_nettype none

module hhc_cell (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [hhc_pkg::KEY_W-1:0]   key,
	input  wire hhc_pkg::action_t            act,
	input  wire hhc_pkg::link_t              link_in,
	output hhc_pkg::link_t                   link_out
);

	logic [hhc_pkg::KEY_W-1:0]      key_q;
	logic [hhc_pkg::COUNT_BITS-1:0] count_q;
	logic                           valid_q;
	logic                           hit_mine_q;
	logic                           free_mine_q;
	logic                           mine_hit;
	logic                           mine_one;

	assign mine_hit = valid_q && (key_q == key);
	assign mine_one = valid_q && (count_q == hhc_pkg::COUNT_BITS'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			link_out <= '0;
		end else begin
			link_out.vld       <= link_in.vld;
			link_out.hit       <= link_in.hit | mine_hit;
			link_out.hit_cnt   <= mine_hit ? count_q : link_in.hit_cnt;
			link_out.free_seen <= link_in.free_seen | !valid_q;
			link_out.used      <= link_in.used + hhc_pkg::USED_W'(valid_q);
			link_out.ones      <= link_in.ones + hhc_pkg::USED_W'(mine_one);
			case (act)
				hhc_pkg::ACT_FILL: begin
					if (free_mine_q) begin
						valid_q <= 1'b1;
					end
				end
				hhc_pkg::ACT_DEC: begin
					if (mine_one) begin
						valid_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (link_in.vld) begin
			hit_mine_q  <= mine_hit;
			free_mine_q <= !valid_q && !link_in.free_seen;
		end
		case (act)
			hhc_pkg::ACT_INC: begin
				if (hit_mine_q) begin
					count_q <= count_q + hhc_pkg::COUNT_BITS'(1);
				end
			end
			hhc_pkg::ACT_FILL: begin
				if (free_mine_q) begin
					key_q   <= key;
					count_q <= hhc_pkg::COUNT_BITS'(1);
				end
			end
			hhc_pkg::ACT_DEC: begin
				if (valid_q) begin
					count_q <= count_q - hhc_pkg::COUNT_BITS'(1);
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== design/heavy_hitter_counter_sketch_top.sv =====
`default_nettype none

// Misra-Gries frequent-item sketch built as a row of SLOTS counter cells. A command is taken
// when start is high and busy is low; a scan beat then walks the row one cell per cycle,
// gathering match, lowest free slot and occupancy. At the edge after the beat leaves the last
// cell the update is applied to all cells at once, and the result is then on the outputs with
// done for one cycle. done rises at the same edge that applies the update, once the beat has
// left the last cell; busy is low again in the cycle done is high, so a new command can be taken
// in that cycle but not before it. The result cannot be held off: capture it while
// done is high.
module heavy_hitter_counter_sketch_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [hhc_pkg::CFG_W-1:0]     cfg_data,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic                          opcode,
	input  wire logic signed [hhc_pkg::KEY_W-1:0] item_value,
	output logic                               done,
	output logic                               status,
	output logic [hhc_pkg::OUT_CNT_W-1:0]      item_count,
	output logic                               tracked,
	output logic [hhc_pkg::TOTAL_W-1:0]        processed_total,
	output logic [hhc_pkg::TOTAL_W-1:0]        decrement_total,
	output logic [hhc_pkg::OUT_USED_W-1:0]     slots_in_use
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SCAN = 2'b10
	} state_t;

	state_t                          state_q;
	logic                            inject_q;
	logic                            op_q;
	logic [hhc_pkg::KEY_W-1:0]       key_q;
	logic [hhc_pkg::CFG_W-1:0]       cfg_q;
	logic [hhc_pkg::TOTAL_W-1:0]     processed_q;
	logic [hhc_pkg::TOTAL_W-1:0]     rounds_q;
	logic                            done_q;

	hhc_pkg::link_t                  links [hhc_pkg::SLOTS+1];
	hhc_pkg::link_t                  tail;
	hhc_pkg::action_t                act;
	logic                            st_ovf;
	logic [hhc_pkg::USED_W-1:0]      limit;
	logic [hhc_pkg::COUNT_BITS-1:0]  cnt_out;
	logic                            cand_out;
	logic [hhc_pkg::USED_W-1:0]      used_out;
	logic [63:0]                     cnt_wide;
	logic                            accept;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign done   = done_q;

	assign links[0] = '{vld: inject_q, hit: 1'b0, hit_cnt: '0, free_seen: 1'b0,
		used: '0, ones: '0};
	assign tail = links[hhc_pkg::SLOTS];

	for (genvar i = 0; i < hhc_pkg::SLOTS; i++) begin : g_cell
		hhc_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.key      (key_q),
			.act      (act),
			.link_in  (links[i]),
			.link_out (links[i+1])
		);
	end

	always_comb begin
		if (cfg_q == '0) begin
			limit = hhc_pkg::USED_W'(1);
		end else if (32'(cfg_q) > hhc_pkg::SLOTS) begin
			limit = hhc_pkg::USED_W'(hhc_pkg::SLOTS);
		end else begin
			limit = hhc_pkg::USED_W'(cfg_q);
		end
	end

	always_comb begin
		act    = hhc_pkg::ACT_NONE;
		st_ovf = 1'b0;
		if (tail.vld && state_q == ST_SCAN && op_q == hhc_pkg::OP_UPDATE) begin
			if (processed_q == '1) begin
				st_ovf = 1'b1;
			end else if (tail.hit) begin
				if (tail.hit_cnt == '1) begin
					st_ovf = 1'b1;
				end else begin
					act = hhc_pkg::ACT_INC;
				end
			end else if (tail.used < limit) begin
				act = hhc_pkg::ACT_FILL;
			end else if (rounds_q == '1) begin
				st_ovf = 1'b1;
			end else begin
				act = hhc_pkg::ACT_DEC;
			end
		end
	end

	always_comb begin
		cnt_out  = tail.hit ? tail.hit_cnt : '0;
		cand_out = tail.hit;
		used_out = tail.used;
		case (act)
			hhc_pkg::ACT_INC: begin
				cnt_out = tail.hit_cnt + hhc_pkg::COUNT_BITS'(1);
			end
			hhc_pkg::ACT_FILL: begin
				cnt_out  = hhc_pkg::COUNT_BITS'(1);
				cand_out = 1'b1;
				used_out = tail.used + hhc_pkg::USED_W'(1);
			end
			hhc_pkg::ACT_DEC: begin
				cnt_out  = '0;
				cand_out = 1'b0;
				used_out = tail.used - tail.ones;
			end
			default: begin
			end
		endcase
		cnt_wide = 64'(cnt_out);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			inject_q    <= 1'b0;
			cfg_q       <= hhc_pkg::CFG_RESET;
			processed_q <= '0;
			rounds_q    <= '0;
			done_q      <= 1'b0;
		end else begin
			inject_q <= accept;
			done_q   <= 1'b0;
			if (cfg_we) begin
				cfg_q <= cfg_data;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (tail.vld) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (act != hhc_pkg::ACT_NONE) begin
				processed_q <= processed_q + hhc_pkg::TOTAL_W'(1);
			end
			if (act == hhc_pkg::ACT_DEC) begin
				rounds_q <= rounds_q + hhc_pkg::TOTAL_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= opcode;
			key_q <= item_value;
		end
		if (tail.vld) begin
			status       <= st_ovf ? hhc_pkg::STATUS_OVERFLOW : hhc_pkg::STATUS_OK;
			item_count   <= (cnt_wide > 64'h0000_0000_FFFF_FFFF) ? '1 : cnt_wide[31:0];
			tracked      <= cand_out;
			slots_in_use <= hhc_pkg::OUT_USED_W'(used_out);
		end
	end

	assign processed_total = processed_q;
	assign decrement_total = rounds_q;

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("done high two cycles in a row");

	a_done_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == ST_SCAN))
		else $error("done without a scan");

	a_tail_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		tail.vld |-> state_q == ST_SCAN)
		else $error("scan beat left the row outside a scan");

	a_ovf_holds_totals: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && status == hhc_pkg::STATUS_OVERFLOW |->
		processed_q == $past(processed_q) && rounds_q == $past(rounds_q))
		else $error("ignored update changed the totals");

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 5000;
	localparam int POOL_SIZE   = 40;

	typedef struct {
		logic                           status;
		logic [hhc_pkg::OUT_CNT_W-1:0]  count;
		logic                           cand;
		logic [hhc_pkg::TOTAL_W-1:0]    processed;
		logic [hhc_pkg::TOTAL_W-1:0]    rounds;
		logic [hhc_pkg::OUT_USED_W-1:0] used;
	} sketch_result_t;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           cfg_we;
	logic [hhc_pkg::CFG_W-1:0]      cfg_data;
	logic                           start;
	logic                           busy;
	logic                           opcode;
	logic [hhc_pkg::KEY_W-1:0]      item_value;
	logic                           done;
	logic                           status;
	logic [hhc_pkg::OUT_CNT_W-1:0]  item_count;
	logic                           tracked;
	logic [hhc_pkg::TOTAL_W-1:0]    processed_total;
	logic [hhc_pkg::TOTAL_W-1:0]    decrement_total;
	logic [hhc_pkg::OUT_USED_W-1:0] slots_in_use;

	logic [hhc_pkg::KEY_W-1:0]      mg_key [hhc_pkg::SLOTS];
	logic [hhc_pkg::COUNT_BITS-1:0] mg_cnt [hhc_pkg::SLOTS];
	logic                           mg_valid [hhc_pkg::SLOTS];
	logic [hhc_pkg::TOTAL_W-1:0]    mg_processed;
	logic [hhc_pkg::TOTAL_W-1:0]    mg_rounds;
	logic [hhc_pkg::CFG_W-1:0]      mg_cfg;

	sketch_result_t                 pending_q [$];
	logic [hhc_pkg::KEY_W-1:0]      key_pool [POOL_SIZE];
	int                             mismatches = 0;
	int                             stall_cycles = 0;
	bit                             no_gaps = 1'b0;

	heavy_hitter_counter_sketch_top u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_data        (cfg_data),
		.start           (start),
		.busy            (busy),
		.opcode          (opcode),
		.item_value      (item_value),
		.done            (done),
		.status          (status),
		.item_count      (item_count),
		.tracked         (tracked),
		.processed_total (processed_total),
		.decrement_total (decrement_total),
		.slots_in_use    (slots_in_use)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int eff_limit();
		int lim;
		lim = int'(mg_cfg);
		if (lim < 1) lim = 1;
		if (lim > hhc_pkg::SLOTS) lim = hhc_pkg::SLOTS;
		return lim;
	endfunction

	function automatic int find_key(input logic [hhc_pkg::KEY_W-1:0] key);
		for (int i = 0; i < hhc_pkg::SLOTS; i++)
			if (mg_valid[i] && mg_key[i] == key) return i;
		return -1;
	endfunction

	function automatic int count_used();
		int n;
		n = 0;
		for (int i = 0; i < hhc_pkg::SLOTS; i++)
			if (mg_valid[i]) n++;
		return n;
	endfunction

	function automatic sketch_result_t sketch_step(input logic op,
			input logic [hhc_pkg::KEY_W-1:0] key);
		sketch_result_t r;
		int hit;
		bit ovf;
		bit placed;
		ovf = 1'b0;
		placed = 1'b0;
		if (op == hhc_pkg::OP_UPDATE) begin
			hit = find_key(key);
			if (mg_processed == '1) begin
				ovf = 1'b1;
			end else if (hit >= 0) begin
				if (mg_cnt[hit] == '1) begin
					ovf = 1'b1;
				end else begin
					mg_cnt[hit] = mg_cnt[hit] + 1'b1;
					mg_processed = mg_processed + 1'b1;
				end
			end else if (count_used() < eff_limit()) begin
				for (int i = 0; i < hhc_pkg::SLOTS; i++) begin
					if (!placed && !mg_valid[i]) begin
						mg_valid[i] = 1'b1;
						mg_key[i] = key;
						mg_cnt[i] = hhc_pkg::COUNT_BITS'(1);
						placed = 1'b1;
					end
				end
				mg_processed = mg_processed + 1'b1;
			end else if (mg_rounds == '1) begin
				ovf = 1'b1;
			end else begin
				for (int i = 0; i < hhc_pkg::SLOTS; i++) begin
					if (mg_valid[i]) begin
						mg_cnt[i] = mg_cnt[i] - 1'b1;
						if (mg_cnt[i] == '0) mg_valid[i] = 1'b0;
					end
				end
				mg_rounds = mg_rounds + 1'b1;
				mg_processed = mg_processed + 1'b1;
			end
		end
		hit = find_key(key);
		r.status    = ovf ? hhc_pkg::STATUS_OVERFLOW : hhc_pkg::STATUS_OK;
		r.count     = (hit >= 0) ? hhc_pkg::OUT_CNT_W'(mg_cnt[hit]) : '0;
		r.cand      = (hit >= 0 && mg_cnt[hit] != '0);
		r.processed = mg_processed;
		r.rounds    = mg_rounds;
		r.used      = hhc_pkg::OUT_USED_W'(count_used());
		return r;
	endfunction

	task automatic check_field(input string name, input logic [63:0] exp_v,
			input logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s expected %h actual %h", $time, name, exp_v, act_v);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		sketch_result_t e;
		if (arst_n && done) begin
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected result beat, expected none actual count %h",
					$time, item_count);
				mismatches++;
			end else begin
				e = pending_q.pop_front();
				check_field("status", 64'(e.status), 64'(status));
				check_field("item_count", 64'(e.count), 64'(item_count));
				check_field("tracked", 64'(e.cand), 64'(tracked));
				check_field("processed_total", 64'(e.processed), 64'(processed_total));
				check_field("decrement_total", 64'(e.rounds), 64'(decrement_total));
				check_field("slots_in_use", 64'(e.used), 64'(slots_in_use));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic send_beat(input logic op, input logic [hhc_pkg::KEY_W-1:0] key);
		@(negedge clk);
		while (busy) @(negedge clk);
		while (!no_gaps && $urandom_range(0, 99) < 32) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start      <= 1'b1;
		opcode     <= op;
		item_value <= key;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_q.insert(pending_q.size(), sketch_step(op, key));
	endtask

	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
	endtask

	task automatic write_limit(input logic [hhc_pkg::CFG_W-1:0] v);
		drain();
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= v;
		mg_cfg = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [hhc_pkg::KEY_W-1:0] rand_key();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [hhc_pkg::KEY_W-1:0] pick_key();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return key_pool[$urandom_range(0, eff_limit() + 2)];
		if (r < 80) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
		return rand_key();
	endfunction

	task automatic test_empty_queries();
		send_beat(hhc_pkg::OP_QUERY, 64'h0);
		send_beat(hhc_pkg::OP_QUERY, '1);
		send_beat(hhc_pkg::OP_QUERY, 64'h8000_0000_0000_0000);
		send_beat(hhc_pkg::OP_QUERY, 64'h7fff_ffff_ffff_ffff);
	endtask

	task automatic test_key_extremes();
		send_beat(hhc_pkg::OP_UPDATE, 64'h8000_0000_0000_0000);
		send_beat(hhc_pkg::OP_UPDATE, 64'h7fff_ffff_ffff_ffff);
		send_beat(hhc_pkg::OP_UPDATE, 64'h0);
		send_beat(hhc_pkg::OP_UPDATE, '1);
		send_beat(hhc_pkg::OP_UPDATE, 64'h8000_0000_0000_0000);
		send_beat(hhc_pkg::OP_QUERY, 64'h8000_0000_0000_0000);
	endtask

	task automatic test_limit_lowered();
		write_limit(hhc_pkg::CFG_W'(1));
		send_beat(hhc_pkg::OP_UPDATE, 64'h5);
		send_beat(hhc_pkg::OP_UPDATE, 64'h8000_0000_0000_0000);
		send_beat(hhc_pkg::OP_UPDATE, 64'h5);
		send_beat(hhc_pkg::OP_UPDATE, 64'h5);
		send_beat(hhc_pkg::OP_QUERY, 64'h7fff_ffff_ffff_ffff);
		send_beat(hhc_pkg::OP_QUERY, 64'h5);
	endtask

	task automatic test_limit_out_of_range();
		write_limit(hhc_pkg::CFG_W'(0));
		send_beat(hhc_pkg::OP_UPDATE, 64'h9);
		send_beat(hhc_pkg::OP_UPDATE, 64'ha);
		write_limit(hhc_pkg::CFG_W'(31));
		send_beat(hhc_pkg::OP_UPDATE, 64'hb);
		send_beat(hhc_pkg::OP_UPDATE, 64'hc);
		write_limit(hhc_pkg::CFG_W'(17));
		send_beat(hhc_pkg::OP_UPDATE, 64'hd);
		send_beat(hhc_pkg::OP_QUERY, 64'hb);
	endtask

	task automatic test_random_stream();
		logic [hhc_pkg::CFG_W-1:0] phase_limits [9];
		logic                      op;
		phase_limits = '{hhc_pkg::CFG_W'(16), hhc_pkg::CFG_W'(1), hhc_pkg::CFG_W'(0),
			hhc_pkg::CFG_W'(31), hhc_pkg::CFG_W'(3), hhc_pkg::CFG_W'(17),
			hhc_pkg::CFG_W'(8), hhc_pkg::CFG_W'(2),
			hhc_pkg::CFG_W'($urandom_range(0, 31))};
		foreach (phase_limits[p]) begin
			write_limit(phase_limits[p]);
			no_gaps = (p == 5);
			for (int n = 0; n < 195; n++) begin
				if (n == 100) drain();
				op = ($urandom_range(0, 99) < 75) ? hhc_pkg::OP_UPDATE : hhc_pkg::OP_QUERY;
				send_beat(op, pick_key());
			end
		end
		no_gaps = 1'b0;
	endtask

	initial begin
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_data   = '0;
		start      = 1'b0;
		opcode     = hhc_pkg::OP_UPDATE;
		item_value = '0;
		for (int i = 0; i < hhc_pkg::SLOTS; i++) begin
			mg_key[i]   = '0;
			mg_cnt[i]   = '0;
			mg_valid[i] = 1'b0;
		end
		mg_processed = '0;
		mg_rounds    = '0;
		mg_cfg       = hhc_pkg::CFG_RESET;
		key_pool[0] = 64'h8000_0000_0000_0000;
		key_pool[1] = 64'h7fff_ffff_ffff_ffff;
		key_pool[2] = 64'h0;
		key_pool[3] = '1;
		for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = rand_key();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_queries();
		test_key_extremes();
		test_limit_lowered();
		test_limit_out_of_range();
		test_random_stream();

		drain();
		repeat (30) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule

`default_nettype wire
